// ===== design/pso_pkg.sv =====
package pso_pkg;

    // Map geometry defaults
    localparam int MAP_WIDTH_DEF  = 256;
    localparam int MAP_HEIGHT_DEF = 256;

    // Divider: quotient bits kept before saturation, plus the range check stage
    localparam int DIV_QBITS = 17;
    localparam int DIV_LAT   = DIV_QBITS + 1;

    // Axis velocity unit depth
    localparam int AX_LAT = 3;

    // Register reset values
    localparam logic [15:0] INERTIA_MIN_RST = 16'd6554;
    localparam logic [15:0] INERTIA_MAX_RST = 16'd14746;
    localparam logic [15:0] SOCIAL_RST      = 16'd16384;
    localparam logic [15:0] COGNITIVE_RST   = 16'd16384;
    localparam logic [6:0]  SPEED_RST       = 7'd40;
    localparam logic [7:0]  LETHAL_RST      = 8'd253;

    typedef enum logic [2:0] {
        REG_INERTIA_MIN  = 3'd0,
        REG_INERTIA_MAX  = 3'd1,
        REG_SOCIAL       = 3'd2,
        REG_COGNITIVE    = 3'd3,
        REG_SPEED_LIMIT  = 3'd4,
        REG_LETHAL       = 3'd5,
        REG_FIT_AVERAGE  = 3'd6,
        REG_FIT_BEST     = 3'd7
    } cfg_idx_t;

    typedef enum logic {
        OP_UPDATE = 1'b0,
        OP_LOAD   = 1'b1
    } op_t;

    // Inertia weight source
    typedef enum logic [1:0] {
        SEL_MAX   = 2'd0,
        SEL_MIN   = 2'd1,
        SEL_BLEND = 2'd2
    } wsel_t;

    // Item fields that ride alongside the divider and the velocity units
    typedef struct packed {
        op_t         op;
        logic [7:0]  px;
        logic [7:0]  py;
        logic [7:0]  vx;
        logic [7:0]  vy;
        logic [7:0]  pbx;
        logic [7:0]  pby;
        logic [7:0]  gbx;
        logic [7:0]  gby;
        logic [31:0] sprod;
        logic [31:0] cprod;
        logic [7:0]  cost;
    } item_t;

    typedef struct packed {
        wsel_t sel;
        logic  dneg;
    } wctl_t;

endpackage

// ===== design/pso_div.sv =====
module pso_div (
    input  logic                             clk,
    input  logic                             en,
    input  logic [47:0]                      num,
    input  logic [31:0]                      den,
    output logic [pso_pkg::DIV_QBITS-1:0]    quo,
    output logic                             ovf
);

    localparam int QB = pso_pkg::DIV_QBITS;
    localparam int RW = 48 + 1;

    logic [RW-1:0] rem_reg [0:QB];
    logic [31:0]   den_reg [0:QB];
    logic [QB-1:0] q_reg   [0:QB];
    logic          ovf_reg [0:QB];

    // Range check: quotient at or above 2^QB saturates downstream
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= {1'b0, num};
            den_reg[0] <= den;
            q_reg[0]   <= '0;
            ovf_reg[0] <= ({1'b0, num} >= {den, {QB{1'b0}}});
        end
    end

    // One quotient bit per stage, most significant first
    for (genvar j = 1; j <= QB; j++)
    begin : g_step
        localparam int B = QB - j;
        logic [RW-1:0] trial;
        logic          ge;

        assign trial = RW'(den_reg[j-1]) << B;
        assign ge    = rem_reg[j-1] >= trial;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[j] <= ge ? (rem_reg[j-1] - trial) : rem_reg[j-1];
                den_reg[j] <= den_reg[j-1];
                q_reg[j]   <= q_reg[j-1] | (QB'(ge) << B);
                ovf_reg[j] <= ovf_reg[j-1];
            end
        end
    end

    assign quo = q_reg[QB];
    assign ovf = ovf_reg[QB];

endmodule

// ===== design/pso_axis.sv =====
module pso_axis (
    input  logic              clk,
    input  logic              en,
    input  logic [15:0]       w,
    input  logic [7:0]        vel,
    input  logic [7:0]        pos,
    input  logic [7:0]        pb,
    input  logic [7:0]        gb,
    input  logic [31:0]       sprod,
    input  logic [31:0]       cprod,
    input  logic [6:0]        lim,
    output logic [7:0]        vel_out
);

    logic signed [24:0] wv_reg;
    logic signed [41:0] ts_reg;
    logic signed [41:0] tc_reg;
    logic signed [43:0] sum_reg;
    logic [7:0]         vel_reg;

    logic signed [8:0]  dpb;
    logic signed [8:0]  dgb;
    logic signed [43:0] sum_next;
    logic [43:0]        mag;
    logic [13:0]        whole;
    logic [7:0]         vel_next;

    assign dpb = $signed({1'b0, pb}) - $signed({1'b0, pos});
    assign dgb = $signed({1'b0, gb}) - $signed({1'b0, pos});

    // Sum in Q.30: inertia term shifted up to match the random-weighted terms
    assign sum_next = (44'(wv_reg) <<< 16) + 44'(ts_reg) + 44'(tc_reg);

    // Truncate toward zero by magnitude, then saturate to the speed limit
    always_comb
    begin
        mag   = sum_reg[43] ? (44'd0 - sum_reg) : sum_reg;
        whole = mag[43:30];
        if (whole > {7'd0, lim})
        begin
            whole = {7'd0, lim};
        end
        vel_next = sum_reg[43] ? (8'd0 - whole[7:0]) : whole[7:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            wv_reg  <= $signed({1'b0, w}) * $signed(vel);
            ts_reg  <= $signed({1'b0, sprod}) * dpb;
            tc_reg  <= $signed({1'b0, cprod}) * dgb;
            sum_reg <= sum_next;
            vel_reg <= vel_next;
        end
    end

    assign vel_out = vel_reg;

endmodule

// ===== design/pso_particle_point_update.sv =====
// Throughput: one item per cycle while no result waits; the divider and multipliers
// are fully pipelined. Load items ride the same pipeline, write the cost store at
// the memory stage and produce no result. The pipeline freezes as a whole while a
// result waits.
// Reset (rst_n low, asynchronous) clears valid bits and loads register defaults;
// the cost store is not cleared and must be loaded before cells are read.
module pso_particle_point_update #(
    parameter int MAP_WIDTH  = pso_pkg::MAP_WIDTH_DEF,
    parameter int MAP_HEIGHT = pso_pkg::MAP_HEIGHT_DEF
) (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,

    input  logic        in_valid,
    output logic        in_ready,
    input  logic        op,
    input  logic [7:0]  pos_x,
    input  logic [7:0]  pos_y,
    input  logic signed [7:0] vel_x,
    input  logic signed [7:0] vel_y,
    input  logic [7:0]  pbest_x,
    input  logic [7:0]  pbest_y,
    input  logic [7:0]  gbest_x,
    input  logic [7:0]  gbest_y,
    input  logic [31:0] fitness_or_cost,
    input  logic [15:0] rand_social,
    input  logic [15:0] rand_cognitive,

    output logic        out_valid,
    input  logic        out_ready,
    output logic signed [7:0] new_vel_x,
    output logic signed [7:0] new_vel_y,
    output logic [7:0]  new_pos_x,
    output logic [7:0]  new_pos_y,
    output logic        moved
);

    // Points are 8 bit, so the usable map never exceeds 256 on a side
    localparam int XLIM  = (MAP_WIDTH  > 256) ? 256 : MAP_WIDTH;
    localparam int YLIM  = (MAP_HEIGHT > 256) ? 256 : MAP_HEIGHT;
    localparam int XW    = $clog2(XLIM);
    localparam int YW    = $clog2(YLIM);
    localparam int DEPTH = 1 << (XW + YW);
    localparam logic [7:0] XMAX = 8'(XLIM - 1);
    localparam logic [7:0] YMAX = 8'(YLIM - 1);

    localparam int DL   = pso_pkg::DIV_LAT;
    localparam int LLEN = DL + 1 + pso_pkg::AX_LAT;

    // ---------------- configuration ----------------
    logic [15:0] imin_reg;
    logic [15:0] imax_reg;
    logic [15:0] sw_reg;
    logic [15:0] cw_reg;
    logic [6:0]  lim_reg;
    logic [7:0]  lethal_reg;
    logic [31:0] avg_reg;
    logic [31:0] best_reg;

    // Writes must arrive only while idle; the block does not enforce this and takes them at once
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            imin_reg   <= pso_pkg::INERTIA_MIN_RST;
            imax_reg   <= pso_pkg::INERTIA_MAX_RST;
            sw_reg     <= pso_pkg::SOCIAL_RST;
            cw_reg     <= pso_pkg::COGNITIVE_RST;
            lim_reg    <= pso_pkg::SPEED_RST;
            lethal_reg <= pso_pkg::LETHAL_RST;
            avg_reg    <= '0;
            best_reg   <= '0;
        end
        else if (cfg_valid)
        begin
            case (pso_pkg::cfg_idx_t'(cfg_index))
                pso_pkg::REG_INERTIA_MIN: imin_reg   <= cfg_data[15:0];
                pso_pkg::REG_INERTIA_MAX: imax_reg   <= cfg_data[15:0];
                pso_pkg::REG_SOCIAL:      sw_reg     <= cfg_data[15:0];
                pso_pkg::REG_COGNITIVE:   cw_reg     <= cfg_data[15:0];
                pso_pkg::REG_SPEED_LIMIT: lim_reg    <= cfg_data[6:0];
                pso_pkg::REG_LETHAL:      lethal_reg <= cfg_data[7:0];
                pso_pkg::REG_FIT_AVERAGE: avg_reg    <= cfg_data;
                pso_pkg::REG_FIT_BEST:    best_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    // ---------------- pipeline control ----------------
    // Every stage advances together; a waiting result freezes the whole pipe
    logic adv;
    logic out_valid_reg;

    assign adv      = !out_valid_reg || out_ready;
    assign in_ready = adv;

    // ---------------- stage 1: decide weight source, random products ----------------
    logic              v1_reg;
    pso_pkg::item_t    it1_reg;
    pso_pkg::wctl_t    ctl1_reg;
    logic [15:0]       dmag1_reg;
    logic [31:0]       numa1_reg;
    logic [31:0]       den1_reg;

    pso_pkg::item_t    it1_next;
    pso_pkg::wctl_t    ctl1_next;
    logic [16:0]       dspan;

    always_comb
    begin
        it1_next.op    = pso_pkg::op_t'(op);
        it1_next.px    = pos_x;
        it1_next.py    = pos_y;
        it1_next.vx    = vel_x;
        it1_next.vy    = vel_y;
        it1_next.pbx   = pbest_x;
        it1_next.pby   = pbest_y;
        it1_next.gbx   = gbest_x;
        it1_next.gby   = gbest_y;
        it1_next.sprod = sw_reg * rand_social;
        it1_next.cprod = cw_reg * rand_cognitive;
        it1_next.cost  = fitness_or_cost[7:0];

        dspan = {1'b0, imax_reg} - {1'b0, imin_reg};
        ctl1_next.dneg = dspan[16];
        if (fitness_or_cost > avg_reg)
        begin
            ctl1_next.sel = pso_pkg::SEL_MAX;
        end
        else if (avg_reg <= best_reg)
        begin
            ctl1_next.sel = pso_pkg::SEL_MIN;
        end
        else
        begin
            ctl1_next.sel = pso_pkg::SEL_BLEND;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            it1_reg   <= it1_next;
            ctl1_reg  <= ctl1_next;
            dmag1_reg <= dspan[16] ? 16'(17'd0 - dspan) : dspan[15:0];
            numa1_reg <= avg_reg - fitness_or_cost;
            den1_reg  <= avg_reg - best_reg;
        end
    end

    // ---------------- stage 2: blend numerator ----------------
    logic           v2_reg;
    pso_pkg::item_t it2_reg;
    pso_pkg::wctl_t ctl2_reg;
    logic [47:0]    num2_reg;
    logic [31:0]    den2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
        end
        else if (adv)
        begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            it2_reg  <= it1_reg;
            ctl2_reg <= ctl1_reg;
            num2_reg <= dmag1_reg * numa1_reg;
            den2_reg <= den1_reg;
        end
    end

    // ---------------- divider and side line ----------------
    logic [pso_pkg::DIV_QBITS-1:0] quo;
    logic                          ovf;

    pso_div u_div (
        .clk (clk),
        .en  (adv),
        .num (num2_reg),
        .den (den2_reg),
        .quo (quo),
        .ovf (ovf)
    );

    // Tap k of the line lines up with divider stage k, then weight, then axis stages
    pso_pkg::item_t it_line  [0:LLEN-1];
    pso_pkg::wctl_t ctl_line [0:LLEN-1];
    logic [LLEN-1:0] v_line;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_line <= '0;
        end
        else if (adv)
        begin
            v_line <= {v_line[LLEN-2:0], v2_reg};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            it_line[0]  <= it2_reg;
            ctl_line[0] <= ctl2_reg;
            for (int k = 1; k < LLEN; k++)
            begin
                it_line[k]  <= it_line[k-1];
                ctl_line[k] <= ctl_line[k-1];
            end
        end
    end

    // ---------------- weight stage ----------------
    logic [15:0] w_reg;
    logic [15:0] w_next;
    logic [17:0] wsum;
    logic [17:0] wdif;

    assign wsum = {2'b00, imin_reg} + {1'b0, quo};
    assign wdif = {2'b00, imin_reg} - {1'b0, quo};

    always_comb
    begin
        case (ctl_line[DL-1].sel)
            pso_pkg::SEL_MAX: w_next = imax_reg;
            pso_pkg::SEL_MIN: w_next = imin_reg;
            default:
            begin
                if (ovf)
                begin
                    w_next = ctl_line[DL-1].dneg ? 16'd0 : 16'hFFFF;
                end
                else if (ctl_line[DL-1].dneg)
                begin
                    w_next = wdif[17] ? 16'd0 : wdif[15:0];
                end
                else
                begin
                    w_next = (wsum[17:16] != 2'b00) ? 16'hFFFF : wsum[15:0];
                end
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            w_reg <= w_next;
        end
    end

    // ---------------- per-axis velocity ----------------
    logic [7:0] vx_new;
    logic [7:0] vy_new;

    pso_axis u_axis_x (
        .clk     (clk),
        .en      (adv),
        .w       (w_reg),
        .vel     (it_line[DL].vx),
        .pos     (it_line[DL].px),
        .pb      (it_line[DL].pbx),
        .gb      (it_line[DL].gbx),
        .sprod   (it_line[DL].sprod),
        .cprod   (it_line[DL].cprod),
        .lim     (lim_reg),
        .vel_out (vx_new)
    );

    pso_axis u_axis_y (
        .clk     (clk),
        .en      (adv),
        .w       (w_reg),
        .vel     (it_line[DL].vy),
        .pos     (it_line[DL].py),
        .pb      (it_line[DL].pby),
        .gb      (it_line[DL].gby),
        .sprod   (it_line[DL].sprod),
        .cprod   (it_line[DL].cprod),
        .lim     (lim_reg),
        .vel_out (vy_new)
    );

    // ---------------- memory stage: clamp, cost read, load write ----------------
    pso_pkg::item_t itv;
    logic           vv;
    logic signed [9:0] tx;
    logic signed [9:0] ty;
    logic [7:0]     nx_next;
    logic [7:0]     ny_next;
    logic           ld_wr;

    assign itv = it_line[LLEN-1];
    assign vv  = v_line[LLEN-1];
    assign tx  = $signed({2'b00, itv.px}) + $signed({{2{vx_new[7]}}, vx_new});
    assign ty  = $signed({2'b00, itv.py}) + $signed({{2{vy_new[7]}}, vy_new});

    always_comb
    begin
        if (tx < 0)
        begin
            nx_next = 8'd0;
        end
        else if (tx > $signed({2'b00, XMAX}))
        begin
            nx_next = XMAX;
        end
        else
        begin
            nx_next = tx[7:0];
        end
        if (ty < 0)
        begin
            ny_next = 8'd0;
        end
        else if (ty > $signed({2'b00, YMAX}))
        begin
            ny_next = YMAX;
        end
        else
        begin
            ny_next = ty[7:0];
        end
    end

    // Drop loads that fall outside the map
    assign ld_wr = vv && (itv.op == pso_pkg::OP_LOAD) && (itv.px <= XMAX) && (itv.py <= YMAX);

    logic [7:0] cost_mem [0:DEPTH-1];
    logic [7:0] cost_q_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            if (ld_wr)
            begin
                cost_mem[{itv.py[YW-1:0], itv.px[XW-1:0]}] <= itv.cost;
            end
            cost_q_reg <= cost_mem[{ny_next[YW-1:0], nx_next[XW-1:0]}];
        end
    end

    logic       v4_reg;
    logic       upd4_reg;
    logic [7:0] vx4_reg;
    logic [7:0] vy4_reg;
    logic [7:0] nx4_reg;
    logic [7:0] ny4_reg;
    logic [7:0] px4_reg;
    logic [7:0] py4_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v4_reg <= 1'b0;
        end
        else if (adv)
        begin
            v4_reg <= vv;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            upd4_reg <= (itv.op == pso_pkg::OP_UPDATE);
            vx4_reg  <= vx_new;
            vy4_reg  <= vy_new;
            nx4_reg  <= nx_next;
            ny4_reg  <= ny_next;
            px4_reg  <= itv.px;
            py4_reg  <= itv.py;
        end
    end

    // ---------------- output register ----------------
    logic       free_cell;
    logic [7:0] nvx_reg;
    logic [7:0] nvy_reg;
    logic [7:0] npx_reg;
    logic [7:0] npy_reg;
    logic       moved_reg;

    assign free_cell = cost_q_reg < lethal_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            // Loads end here without a result
            out_valid_reg <= v4_reg && upd4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            nvx_reg   <= vx4_reg;
            nvy_reg   <= vy4_reg;
            npx_reg   <= free_cell ? nx4_reg : px4_reg;
            npy_reg   <= free_cell ? ny4_reg : py4_reg;
            moved_reg <= free_cell;
        end
    end

    assign out_valid = out_valid_reg;
    assign new_vel_x = nvx_reg;
    assign new_vel_y = nvy_reg;
    assign new_pos_x = npx_reg;
    assign new_pos_y = npy_reg;
    assign moved     = moved_reg;

`ifndef NO_ASSERTIONS
    // A load in the memory stage never turns into a result
    a_load_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        (adv && v4_reg && !upd4_reg) |=> !out_valid_reg)
        else $error("load produced a result");

    // Weight follows inertia_max when fitness is above average
    a_weight_max: assert property (@(posedge clk) disable iff (!rst_n)
        (adv && v_line[DL-1] && ctl_line[DL-1].sel == pso_pkg::SEL_MAX && !cfg_valid)
        |=> (w_reg == imax_reg))
        else $error("weight not at maximum");

    // A result that is held must not be overwritten
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |=> (out_valid_reg && $stable(npx_reg) && $stable(nvx_reg)))
        else $error("held result changed");

    // A blocked move leaves the position where it was
    a_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        (adv && v4_reg && upd4_reg && !free_cell) |=> (!moved_reg && npx_reg == $past(px4_reg)))
        else $error("blocked move changed position");
`endif

endmodule
